// File: hdl/sfcc_pkg.sv
package sfcc_pkg;

    localparam int FRAME_BYTES = 5;
    localparam int POS_W       = 3;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

    localparam logic [7:0] CRC_POLY  = 8'h31;
    localparam logic [7:0] CRC_START = 8'hFF;

    localparam logic [1:0] ERR_OK        = 2'd0;
    localparam logic [1:0] ERR_READ      = 2'd1;
    localparam logic [1:0] ERR_NOT_READY = 2'd2;
    localparam logic [1:0] ERR_CRC       = 2'd3;

    typedef struct packed {
        logic       unit_select;
        logic       read_abort;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic        fresh;
        logic [7:0]  status_byte;
        logic [1:0]  error_code;
        logic [23:0] reading;
    } t_result;

    // MSB-first CRC-8, eight shift-xor steps
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: hdl/sfcc_in_stage.sv
module sfcc_in_stage
    import sfcc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    input  logic     i_advance,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid, n_valid;
    t_in_item r_item;
    logic     accept;

    assign o_ready = !r_valid || i_advance;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: hdl/sfcc_frame_core.sv
module sfcc_frame_core
    import sfcc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_in_item i_item,
    input  logic     i_fire,
    output logic     o_done,
    output t_result  o_result
);

    logic [POS_W-1:0] r_pos;
    logic [7:0]       r_crc;
    logic [23:0]      r_value;
    logic [7:0]       r_frame_status;
    logic [7:0]       r_held_status;
    logic [23:0]      r_good_ppb;
    logic [23:0]      r_good_ugm3;

    logic [7:0]  crc_nxt;
    logic        is_last;
    logic [1:0]  err;
    logic [23:0] last_good;

    assign crc_nxt   = crc8_next(r_crc, i_item.data_byte);
    assign is_last   = (r_pos >= LAST_POS);
    assign o_done    = i_item.read_abort || is_last;
    assign last_good = i_item.unit_select ? r_good_ugm3 : r_good_ppb;

    // CRC over the whole frame must come out zero; CRC error wins over not ready
    always_comb begin
        if (i_item.read_abort) begin
            err = ERR_READ;
        end else if (crc_nxt != 8'h00) begin
            err = ERR_CRC;
        end else if (r_frame_status[0]) begin
            err = ERR_NOT_READY;
        end else begin
            err = ERR_OK;
        end
    end

    always_comb begin
        o_result.error_code  = err;
        o_result.fresh       = (err == ERR_OK);
        o_result.reading     = (err == ERR_OK) ? r_value : last_good;
        o_result.status_byte = i_item.read_abort ? r_held_status : r_frame_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos          <= '0;
            r_crc          <= CRC_START;
            r_value        <= '0;
            r_frame_status <= '0;
            r_held_status  <= '0;
            r_good_ppb     <= '0;
            r_good_ugm3    <= '0;
        end else if (i_fire) begin
            if (o_done) begin
                // end of frame: restart; unless aborted, commit status and, if error-free, the good reading
                r_pos          <= '0;
                r_crc          <= CRC_START;
                r_value        <= '0;
                r_frame_status <= '0;
                if (!i_item.read_abort) begin
                    r_held_status <= r_frame_status;
                    if (err == ERR_OK) begin
                        if (i_item.unit_select) begin
                            r_good_ugm3 <= r_value;
                        end else begin
                            r_good_ppb <= r_value;
                        end
                    end
                end
            end else begin
                r_crc <= crc_nxt;
                r_pos <= r_pos + POS_W'(1);
                if (r_pos == '0) begin
                    r_frame_status <= i_item.data_byte;
                end else begin
                    r_value <= {r_value[15:0], i_item.data_byte};
                end
            end
        end
    end

endmodule

// File: hdl/sfcc_out_stage.sv
module sfcc_out_stage
    import sfcc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid, n_valid;
    t_result r_result;

    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: hdl/sensor_frame_crc_checker.sv
// Channel   Direction  Payload
// s_axis    in         tdata: data_byte[7:0]; tuser: read_abort[0], unit_select[1]
// m_axis    out        tdata: reading[23:0], status_byte[31:24];
//                      tuser: error_code[1:0], fresh[2]
//
// One byte is taken per cycle unless a stalled result holds the input register;
// the result of a frame passes through an input register and a result register.
// The CRC step is eight unrolled shift-xor stages, computed combinationally.
// Synchronous active-low reset clears frame state and the last good readings.
// A stalled result stops the input register only when the waiting byte
// ends a frame; mid-frame bytes keep flowing.
module sensor_frame_crc_checker
    import sfcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic [1:0]  s_axis_tuser,   // read_abort, unit_select
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // reading[23:0], status_byte[31:24]
    output logic [2:0]  m_axis_tuser    // error_code[1:0], fresh[2]
);

    t_in_item in_item, stage_item;
    t_result  core_result, out_result;
    logic     stage_valid, core_done, out_free, fire;

    always_comb begin
        in_item.data_byte   = s_axis_tdata;
        in_item.read_abort  = s_axis_tuser[0];
        in_item.unit_select = s_axis_tuser[1];
    end

    // advance the held item unless it ends a frame and the result slot is taken
    assign fire = stage_valid && (!core_done || out_free);

    sfcc_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (in_item),
        .i_advance (fire),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    sfcc_frame_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (stage_item),
        .i_fire   (fire),
        .o_done   (core_done),
        .o_result (core_result)
    );

    sfcc_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire && core_done),
        .i_result (core_result),
        .o_free   (out_free),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_result)
    );

    assign m_axis_tdata = {out_result.status_byte, out_result.reading};
    assign m_axis_tuser = {out_result.fresh, out_result.error_code};

endmodule
